### design/shq_pkg.sv
// Shared types, constants and helper functions for the shell quote stream unit.
// No dependencies; every design file refers to it by scoped names.
package shq_pkg;

  localparam int EOL_MAX_BYTES = 8;
  localparam int EOL_LEN_W     = 4;
  localparam int LIST_MAX      = 5;
  localparam int LIST_CNT_W    = $clog2(LIST_MAX + 1);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [2:0] REG_MAGIC_LOW   = 3'd0;
  localparam logic [2:0] REG_MAGIC_HIGH  = 3'd1;
  localparam logic [2:0] REG_EXPOSE_LOW  = 3'd2;
  localparam logic [2:0] REG_EXPOSE_HIGH = 3'd3;
  localparam logic [2:0] REG_NODQ_LOW    = 3'd4;
  localparam logic [2:0] REG_NODQ_HIGH   = 3'd5;
  localparam logic [2:0] REG_EOL_BYTES   = 3'd6;
  localparam logic [2:0] REG_CONTROL     = 3'd7;

  typedef struct packed {
    logic [63:0]          magic_low;
    logic [63:0]          magic_high;
    logic [63:0]          expose_low;
    logic [63:0]          expose_high;
    logic [63:0]          nodq_low;
    logic [63:0]          nodq_high;
    logic [63:0]          eol_bytes;
    logic [1:0]           outer;
    logic [EOL_LEN_W-1:0] eol_len;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [1:0] outer;
  } reload_t;

  typedef struct packed {
    logic [LIST_MAX-1:0][7:0] bytes;
    logic [LIST_CNT_W-1:0]    count;
    logic                     eol;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic logic [1:0] outer_of(input logic [5:0] ctrl);
    outer_of = (ctrl[1:0] == 2'd3) ? QUOTE_NONE : ctrl[1:0];
  endfunction

  function automatic logic [EOL_LEN_W-1:0] eol_len_of(input logic [5:0] ctrl);
    eol_len_of = (ctrl[5:2] > EOL_LEN_W'(EOL_MAX_BYTES)) ?
                 EOL_LEN_W'(EOL_MAX_BYTES) : ctrl[5:2];
  endfunction

  function automatic logic [7:0] quote_byte(input logic [1:0] q);
    quote_byte = (q == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  function automatic logic in_set(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [7:0] c);
    if (c[7]) begin
      in_set = 1'b0;
    end else if (c[6]) begin
      in_set = hi[c[5:0]];
    end else begin
      in_set = lo[c[5:0]];
    end
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### design/shq_regs.sv
// Configuration registers of the shell quote stream unit.
// Depends on shq_pkg.
module shq_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  output shq_pkg::cfg_t         cfg,
  output shq_pkg::reload_t      reload
);

  logic [63:0] magic_low, magic_high, expose_low, expose_high;
  logic [63:0] nodq_low, nodq_high, eol_bytes;
  logic [5:0]  control;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_low   <= '0;
      magic_high  <= '0;
      expose_low  <= '0;
      expose_high <= '0;
      nodq_low    <= '0;
      nodq_high   <= '0;
      eol_bytes   <= '0;
      control     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shq_pkg::REG_MAGIC_LOW:   magic_low   <= cfg_data;
        shq_pkg::REG_MAGIC_HIGH:  magic_high  <= cfg_data;
        shq_pkg::REG_EXPOSE_LOW:  expose_low  <= cfg_data;
        shq_pkg::REG_EXPOSE_HIGH: expose_high <= cfg_data;
        shq_pkg::REG_NODQ_LOW:    nodq_low    <= cfg_data;
        shq_pkg::REG_NODQ_HIGH:   nodq_high   <= cfg_data;
        shq_pkg::REG_EOL_BYTES:   eol_bytes   <= cfg_data;
        shq_pkg::REG_CONTROL:     control     <= cfg_data[5:0];
        default:                  control     <= control;
      endcase
    end
  end

  always_comb begin
    cfg.magic_low   = magic_low;
    cfg.magic_high  = magic_high;
    cfg.expose_low  = expose_low;
    cfg.expose_high = expose_high;
    cfg.nodq_low    = nodq_low;
    cfg.nodq_high   = nodq_high;
    cfg.eol_bytes   = eol_bytes;
    cfg.outer       = shq_pkg::outer_of(control);
    cfg.eol_len     = shq_pkg::eol_len_of(control);
    reload.load     = cfg_we && (cfg_index == shq_pkg::REG_CONTROL);
    reload.outer    = shq_pkg::outer_of(cfg_data[5:0]);
  end

endmodule

### design/shq_front.sv
// Front end: accepts characters, tracks the quote state and builds one
// output descriptor per character. Depends on shq_pkg.
module shq_front (
  input  logic             clk,
  input  logic             rst,
  input  shq_pkg::cfg_t    cfg,
  input  shq_pkg::reload_t reload,
  input  logic             accept,
  input  logic [7:0]       ch,
  input  logic             end_of_string,
  output shq_pkg::desc_t   desc
);

  logic [1:0] open_quote, pending_quote;
  logic [1:0] oq, pq, other;
  logic [shq_pkg::LIST_CNT_W-1:0] n;
  logic [shq_pkg::LIST_MAX-1:0][7:0] b;
  logic eol, is_quote, self_open, tick;

  always_comb begin
    oq = open_quote;
    pq = pending_quote;
    n = '0;
    b = '0;
    eol = 1'b0;
    tick = cfg.nodq_high[32];
    is_quote = (ch == shq_pkg::CH_SQUOTE) || (ch == shq_pkg::CH_DQUOTE) ||
               (ch == shq_pkg::CH_TICK && tick);
    other = (ch == shq_pkg::CH_SQUOTE) ? shq_pkg::QUOTE_DOUBLE : shq_pkg::QUOTE_SINGLE;
    self_open = (ch == shq_pkg::CH_SQUOTE && oq == shq_pkg::QUOTE_SINGLE) ||
                (ch == shq_pkg::CH_DQUOTE && oq == shq_pkg::QUOTE_DOUBLE);

    if (is_quote && oq != other) begin
      if (self_open) begin
        b[n] = ch; n = n + 1'b1;
      end else if (oq != shq_pkg::QUOTE_NONE && ch == shq_pkg::CH_TICK) begin
        b[n] = shq_pkg::quote_byte(oq); n = n + 1'b1;
      end
      b[n] = shq_pkg::quote_byte(other); n = n + 1'b1;
      oq = other;
      b[n] = ch; n = n + 1'b1;
    end else if (cfg.eol_len != '0 && (ch == shq_pkg::CH_LF || ch == shq_pkg::CH_CR)) begin
      if (oq != cfg.outer) begin
        if (oq != shq_pkg::QUOTE_NONE) begin
          b[n] = shq_pkg::quote_byte(oq); n = n + 1'b1;
        end
        if (cfg.outer != shq_pkg::QUOTE_NONE) begin
          b[n] = shq_pkg::quote_byte(cfg.outer); n = n + 1'b1;
        end
        oq = cfg.outer;
      end
      eol = 1'b1;
    end else begin
      if (oq == shq_pkg::QUOTE_DOUBLE && shq_pkg::in_set(cfg.nodq_low, cfg.nodq_high, ch)) begin
        b[n] = shq_pkg::CH_DQUOTE; n = n + 1'b1;
        oq = shq_pkg::QUOTE_NONE;
        pq = shq_pkg::QUOTE_SINGLE;
      end
      if ((shq_pkg::is_ws(ch) && cfg.expose_low[32]) ||
          shq_pkg::in_set(cfg.expose_low, cfg.expose_high, ch)) begin
        if (oq != cfg.outer) begin
          if (oq != shq_pkg::QUOTE_NONE) begin
            b[n] = shq_pkg::quote_byte(oq); n = n + 1'b1;
          end
          if (cfg.outer != shq_pkg::QUOTE_NONE) begin
            b[n] = shq_pkg::quote_byte(cfg.outer); n = n + 1'b1;
          end
          oq = cfg.outer;
        end
      end else if (oq == shq_pkg::QUOTE_NONE &&
                   ((shq_pkg::is_ws(ch) && cfg.magic_low[32]) ||
                    shq_pkg::in_set(cfg.magic_low, cfg.magic_high, ch))) begin
        if (pq == shq_pkg::QUOTE_NONE) begin
          pq = (cfg.outer != shq_pkg::QUOTE_NONE) ? cfg.outer : shq_pkg::QUOTE_SINGLE;
        end
        oq = pq;
        b[n] = shq_pkg::quote_byte(oq); n = n + 1'b1;
        pq = cfg.outer;
      end
      b[n] = ch; n = n + 1'b1;
    end

    if (end_of_string) begin
      if (oq != cfg.outer) begin
        if (oq != shq_pkg::QUOTE_NONE) begin
          b[n] = shq_pkg::quote_byte(oq); n = n + 1'b1;
        end
        if (cfg.outer != shq_pkg::QUOTE_NONE) begin
          b[n] = shq_pkg::quote_byte(cfg.outer); n = n + 1'b1;
        end
      end
      oq = cfg.outer;
      pq = cfg.outer;
    end

    desc.bytes = b;
    desc.count = n;
    desc.eol   = eol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_quote    <= shq_pkg::QUOTE_NONE;
      pending_quote <= shq_pkg::QUOTE_NONE;
    end else if (reload.load) begin
      open_quote    <= reload.outer;
      pending_quote <= reload.outer;
    end else if (accept) begin
      open_quote    <= oq;
      pending_quote <= pq;
    end
  end

endmodule

### design/shq_queue.sv
// Short descriptor queue between the front end and the byte emitter.
// Depends on shq_pkg.
module shq_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  shq_pkg::desc_t       push_desc,
  input  logic                 pop,
  output shq_pkg::desc_t       head,
  output shq_pkg::queue_stat_t stat
);

  shq_pkg::desc_t mem [shq_pkg::QUEUE_DEPTH];
  logic [shq_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [shq_pkg::QPTR_W:0]   level;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_comb begin
    head       = mem[rd_ptr];
    stat.full  = (level == (shq_pkg::QPTR_W + 1)'(shq_pkg::QUEUE_DEPTH));
    stat.empty = (level == '0);
  end

endmodule

### design/shq_back.sv
// Back end: expands queued descriptors into output bytes, one per cycle
// unless stalled, through a registered output stage. Depends on shq_pkg.
module shq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  shq_pkg::cfg_t        cfg,
  input  shq_pkg::desc_t       head,
  input  shq_pkg::queue_stat_t stat,
  output logic                 pop,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output logic [7:0]           out_byte,
  output logic                 last
);

  logic [3:0] idx, total, eol_idx;
  logic [7:0] sel_byte;
  logic       load, is_last;

  always_comb begin
    total   = 4'(head.count) + (head.eol ? cfg.eol_len : 4'd0);
    is_last = (idx == total - 4'd1);
    eol_idx = idx - 4'(head.count);
    if (idx < 4'(head.count)) begin
      sel_byte = head.bytes[idx[2:0]];
    end else begin
      sel_byte = cfg.eol_bytes[{eol_idx[2:0], 3'b000} +: 8];
    end
    load = !stat.empty && (!byte_valid || !byte_stall);
    pop  = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      byte_valid <= 1'b0;
    end else if (load) begin
      idx        <= is_last ? 4'd0 : idx + 4'd1;
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      last     <= is_last;
    end
  end

endmodule

### design/shell_quote_stream_unit.sv
// Shell quote stream unit: one character in, one or more quoted bytes out.
// Path: a character's descriptor is queued, then its bytes are registered out.
// Throughput: one character per cycle unless the 4-entry descriptor queue is
// full; one output byte per cycle unless stalled; 1 to 10 bytes per character.
// Reset: config registers zero, quote state none, queue and output empty.
module shell_quote_stream_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  ch,
  input  logic        end_of_string,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last
);

  shq_pkg::cfg_t        cfg;
  shq_pkg::reload_t     reload;
  shq_pkg::desc_t       new_desc, head;
  shq_pkg::queue_stat_t q_stat;
  logic                 accept, pop;

  assign item_stall = q_stat.full;
  assign accept     = item_valid && !item_stall;

  shq_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .reload    (reload)
  );

  shq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .reload        (reload),
    .accept        (accept),
    .ch            (ch),
    .end_of_string (end_of_string),
    .desc          (new_desc)
  );

  shq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_desc (new_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  shq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last       (last)
  );

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> !q_stat.empty)
    else $error("queue empty after accepting an item");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !byte_valid && q_stat.empty)
    else $error("output or queue busy after reset");

endmodule
